// ===== hw/rtl/tlik_pkg.sv =====
// ----------------------------------------------------------------------------
// tlik_pkg
// shared constants, types and tables of the two-link inverse kinematics solver
// ----------------------------------------------------------------------------
package tlik_pkg;

   localparam int COORD_WIDTH  = 16;
   localparam int CORDIC_STEPS = 16;

   localparam int LINK_W     = 15;
   localparam int SQ_W       = 2 * COORD_WIDTH;
   localparam int NUM_W      = 2 * COORD_WIDTH + 2;
   localparam int DEN_W      = 2 * LINK_W + 1;
   localparam int Q_W        = 31;
   localparam int C_W        = Q_W + 1;
   localparam int RAD_W      = 62;
   localparam int ROOT_W     = RAD_W / 2;
   localparam int SREM_W     = ROOT_W + 2;
   localparam int PS_W       = LINK_W + ROOT_W;
   localparam int GX_W       = LINK_W + C_W + 1;
   localparam int CV_W       = 50;
   localparam int ANG_W      = 26;
   localparam int RAW_W      = ANG_W + 1;
   localparam int IDX_W      = 5;
   localparam int PRESCALE   = 40 - COORD_WIDTH;
   localparam int ONE_SHIFT  = 30;
   localparam int SHOULDER_W = 18;
   localparam int ELBOW_W    = 16;

   localparam int DIV_CELLS  = Q_W;
   localparam int SQRT_CELLS = ROOT_W;

   // pipeline stage indexes
   localparam int ST_IN     = 0;
   localparam int ST_SQ     = 1;
   localparam int ST_NUM    = 2;
   localparam int ST_MAG    = 3;
   localparam int ST_DIV    = 4;
   localparam int ST_C      = ST_DIV + DIV_CELLS;
   localparam int ST_CSQ    = ST_C + 1;
   localparam int ST_RAD    = ST_C + 2;
   localparam int ST_SQRT   = ST_C + 3;
   localparam int ST_G1     = ST_SQRT + SQRT_CELLS;
   localparam int ST_G2     = ST_G1 + 1;
   localparam int ST_PRE    = ST_G1 + 2;
   localparam int ST_CORDIC = ST_PRE + 1;
   localparam int ST_FIN    = ST_CORDIC + CORDIC_STEPS;
   localparam int LATENCY   = ST_FIN + 2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic REG_UPPER = 1'b0;
   localparam logic REG_LOWER = 1'b1;

   localparam logic [LINK_W-1:0] UPPER_RESET = LINK_W'(100);
   localparam logic [LINK_W-1:0] LOWER_RESET = LINK_W'(80);

   localparam logic signed [ANG_W-1:0] DEG90  = ANG_W'(90 * 65536);
   localparam logic signed [ANG_W-1:0] DEG180 = ANG_W'(180 * 65536);

   localparam logic signed [RAW_W-1:0] ROUND_HALF   = RAW_W'(128);
   localparam logic signed [RAW_W-1:0] SHOULDER_MIN = -RAW_W'(92160);
   localparam logic signed [RAW_W-1:0] SHOULDER_MAX = RAW_W'(46080);
   localparam logic signed [RAW_W-1:0] ELBOW_MIN    = RAW_W'(0);
   localparam logic signed [RAW_W-1:0] ELBOW_MAX    = RAW_W'(46080);

   localparam int ANGLE_GROUPS = 3;
   localparam int GRP_ALPHA    = 0;
   localparam int GRP_BETA     = 1;
   localparam int GRP_GAMMA    = 2;

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [DEN_W-1:0] den;
      logic [Q_W-1:0]   q;
   } div_type;

   typedef struct packed {
      logic [SREM_W-1:0] rem;
      logic [ROOT_W-1:0] root;
      logic [RAD_W-1:0]  rad;
   } sqrt_type;

   typedef struct packed {
      logic signed [CV_W-1:0]  x;
      logic signed [CV_W-1:0]  y;
      logic signed [ANG_W-1:0] z;
   } cordic_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic [LINK_W-1:0]             l1;
      logic [LINK_W-1:0]             l2;
      logic                          neg;
      logic                          flag;
      logic signed [C_W-1:0]         c;
      logic [ANGLE_GROUPS-1:0]       zero;
   } side_type;

   // atan(2^-i) in degrees * 2^16, rounded to nearest
   function automatic logic signed [ANG_W-1:0] atan_deg(input logic [IDX_W-1:0] idx);
      logic signed [ANG_W-1:0] v;
      case (idx)
         5'd0:    v = ANG_W'(2949120);
         5'd1:    v = ANG_W'(1740967);
         5'd2:    v = ANG_W'(919879);
         5'd3:    v = ANG_W'(466945);
         5'd4:    v = ANG_W'(234379);
         5'd5:    v = ANG_W'(117304);
         5'd6:    v = ANG_W'(58666);
         5'd7:    v = ANG_W'(29335);
         5'd8:    v = ANG_W'(14668);
         5'd9:    v = ANG_W'(7334);
         5'd10:   v = ANG_W'(3667);
         5'd11:   v = ANG_W'(1833);
         5'd12:   v = ANG_W'(917);
         5'd13:   v = ANG_W'(458);
         5'd14:   v = ANG_W'(229);
         5'd15:   v = ANG_W'(115);
         5'd16:   v = ANG_W'(57);
         5'd17:   v = ANG_W'(29);
         5'd18:   v = ANG_W'(14);
         5'd19:   v = ANG_W'(7);
         5'd20:   v = ANG_W'(4);
         5'd21:   v = ANG_W'(2);
         5'd22:   v = ANG_W'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

   // quarter-turn pre-rotation for a vector in the left half plane
   function automatic cordic_type cordic_prerot(input logic signed [CV_W-1:0] x,
                                                input logic signed [CV_W-1:0] y);
      cordic_type r;
      r.x = x;
      r.y = y;
      r.z = '0;
      if (x < 0) begin
         if (y >= 0) begin
            r.x = y;
            r.y = -x;
            r.z = DEG90;
         end else begin
            r.x = -y;
            r.y = x;
            r.z = -DEG90;
         end
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/tlik_div_cell.sv =====
// ----------------------------------------------------------------------------
// tlik_div_cell
// one quotient bit of the restoring divider for the elbow cosine
// ----------------------------------------------------------------------------
module tlik_div_cell (
   input  logic              clock,
   input  logic              en,
   input  logic              bit_in,
   input  tlik_pkg::div_type up,
   output tlik_pkg::div_type down
);
   import tlik_pkg::*;

   logic [DEN_W:0] trial;
   logic [DEN_W:0] diff;
   logic           ge;
   div_type        down_in;
   div_type        down_ff;

   always_comb begin
      trial        = {up.rem, bit_in};
      diff         = trial - {1'b0, up.den};
      ge           = trial >= {1'b0, up.den};
      down_in.rem  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      down_in.den  = up.den;
      down_in.q    = {up.q[Q_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         down_ff <= down_in;
      end
   end

   assign down = down_ff;

endmodule

// ===== hw/rtl/tlik_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// tlik_sqrt_cell
// one root bit of the digit-by-digit square root of the elbow sine
// ----------------------------------------------------------------------------
module tlik_sqrt_cell (
   input  logic               clock,
   input  logic               en,
   input  logic [1:0]         pair,
   input  tlik_pkg::sqrt_type up,
   output tlik_pkg::sqrt_type down
);
   import tlik_pkg::*;

   logic [SREM_W+1:0] cur;
   logic [SREM_W+1:0] trial;
   logic [SREM_W+1:0] diff;
   logic              ge;
   sqrt_type          down_in;
   sqrt_type          down_ff;

   always_comb begin
      cur          = {up.rem, pair};
      trial        = (SREM_W + 2)'({up.root, 2'b01});
      diff         = cur - trial;
      ge           = cur >= trial;
      down_in.rem  = ge ? diff[SREM_W-1:0] : cur[SREM_W-1:0];
      down_in.root = {up.root[ROOT_W-2:0], ge};
      down_in.rad  = up.rad;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         down_ff <= down_in;
      end
   end

   assign down = down_ff;

endmodule

// ===== hw/rtl/tlik_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// tlik_cordic_cell
// one micro-rotation of the vectoring cordic, angle in degrees * 2^16
// ----------------------------------------------------------------------------
module tlik_cordic_cell (
   input  logic                       clock,
   input  logic                       en,
   input  logic [tlik_pkg::IDX_W-1:0] step,
   input  tlik_pkg::cordic_type       up,
   output tlik_pkg::cordic_type       down
);
   import tlik_pkg::*;

   logic signed [CV_W-1:0]  xv;
   logic signed [CV_W-1:0]  yv;
   logic signed [CV_W-1:0]  xs;
   logic signed [CV_W-1:0]  ys;
   logic signed [ANG_W-1:0] da;
   cordic_type              down_in;
   cordic_type              down_ff;

   always_comb begin
      xv = up.x;
      yv = up.y;
      xs = xv >>> step;
      ys = yv >>> step;
      da = atan_deg(step);
      if (yv > 0) begin
         down_in.x = xv + ys;
         down_in.y = yv - xs;
         down_in.z = up.z + da;
      end else begin
         down_in.x = xv - ys;
         down_in.y = yv + xs;
         down_in.z = up.z - da;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         down_ff <= down_in;
      end
   end

   assign down = down_ff;

endmodule

// ===== hw/rtl/two_link_arm_inverse_kinematics_top.sv =====
// throughput: one transaction per cycle; a stalled response holds the whole pipeline
// the depth is set by the 31-cell divider, the 31-cell square root and 16 cordic cells
// reset clears every stage valid and loads link lengths 100 and 80
// ----------------------------------------------------------------------------
// two_link_arm_inverse_kinematics_top
// pipelined two-link planar arm solver: shoulder and elbow angles per target
// ----------------------------------------------------------------------------
module two_link_arm_inverse_kinematics_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [tlik_pkg::COORD_WIDTH-1:0] req_target_x,
   input  logic signed [tlik_pkg::COORD_WIDTH-1:0] req_target_y,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [tlik_pkg::SHOULDER_W-1:0] rsp_shoulder_angle,
   output logic [tlik_pkg::ELBOW_W-1:0]           rsp_elbow_angle,
   output logic                                   rsp_out_of_reach,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [tlik_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [tlik_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [tlik_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready
);
   import tlik_pkg::*;

   logic                adv;
   logic [LATENCY-1:0]  vld_ff;
   logic [LATENCY-1:0]  vld_in;
   logic [LINK_W-1:0]   upper_ff;
   logic [LINK_W-1:0]   lower_ff;
   logic                csr_wr;

   side_type side_ff [ST_FIN+1];
   side_type side_in [ST_FIN+1];

   logic signed [SQ_W-1:0]     xx_ff, xx_in, yy_ff, yy_in;
   logic [2*LINK_W-1:0]        l1sq_ff, l1sq_in, l2sq_ff, l2sq_in, lprod;
   logic [DEN_W-1:0]           den1_ff, den1_in, den2_ff, den3_ff;
   logic signed [NUM_W-1:0]    num_ff, num_in;
   logic [NUM_W-1:0]           magw;
   logic                       num_neg;
   logic                       num_far;
   logic [DEN_W-1:0]           mag_ff, mag_in;

   div_type                    div_up [DIV_CELLS];
   div_type                    div_dn [DIV_CELLS];
   logic [DIV_CELLS-1:0]       div_bit;
   logic [Q_W-1:0]             quo;

   logic signed [RAD_W-1:0]    csq_ff, csq_in;
   logic [RAD_W-1:0]           rad_ff, rad_in;
   sqrt_type                   sq_up [SQRT_CELLS];
   sqrt_type                   sq_dn [SQRT_CELLS];
   logic [1:0]                 sq_pair [SQRT_CELLS];

   logic [PS_W-1:0]            ps_ff, ps_in, gy_ff;
   logic signed [GX_W-1:0]     pc_ff, pc_in, gx_ff, gx_in;
   logic [ROOT_W-1:0]          s1_ff, s2_ff;

   logic signed [CV_W-1:0]     op_x [ANGLE_GROUPS];
   logic signed [CV_W-1:0]     op_y [ANGLE_GROUPS];
   cordic_type                 pre_ff [ANGLE_GROUPS];
   cordic_type                 pre_in [ANGLE_GROUPS];
   logic [ANGLE_GROUPS-1:0]    zero_in;
   cordic_type                 cd_dn [ANGLE_GROUPS][CORDIC_STEPS];
   logic signed [ANG_W-1:0]    ang [ANGLE_GROUPS];

   logic signed [RAW_W-1:0]    sh_ff, sh_in, el_ff, el_in;
   logic signed [RAW_W-1:0]    sh_rnd, el_rnd, sh_cl, el_cl;
   logic signed [SHOULDER_W-1:0] rsp_sh_ff;
   logic [ELBOW_W-1:0]         rsp_el_ff;
   logic                       rsp_flag_ff;

   // ---------------------------------------------------------------- control
   assign adv       = !vld_ff[LATENCY-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[LATENCY-1];
   assign vld_in    = {vld_ff[LATENCY-2:0], req_valid & adv};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // ---------------------------------------------------------------- registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= UPPER_RESET;
         lower_ff <= LOWER_RESET;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            REG_UPPER: upper_ff <= csr_pwdata[LINK_W-1:0];
            REG_LOWER: lower_ff <= csr_pwdata[LINK_W-1:0];
            default:   upper_ff <= upper_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_UPPER: csr_prdata = CSR_DATA_W'(upper_ff);
         REG_LOWER: csr_prdata = CSR_DATA_W'(lower_ff);
         default:   csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- side data
   always_comb begin
      side_in[0].x    = req_target_x;
      side_in[0].y    = req_target_y;
      // a zero length acts as one
      side_in[0].l1   = (upper_ff == '0) ? LINK_W'(1) : upper_ff;
      side_in[0].l2   = (lower_ff == '0) ? LINK_W'(1) : lower_ff;
      side_in[0].neg  = 1'b0;
      side_in[0].flag = 1'b0;
      side_in[0].c    = '0;
      side_in[0].zero = '0;
      for (int k = 1; k <= ST_FIN; k++) begin
         side_in[k] = side_ff[k-1];
      end
      side_in[ST_MAG].neg  = num_neg;
      side_in[ST_MAG].flag = num_far;
      side_in[ST_C].c      = side_ff[ST_C-1].neg ? -C_W'(quo) : C_W'(quo);
      side_in[ST_PRE].zero = zero_in;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= ST_FIN; k++) begin
            side_ff[k] <= side_in[k];
         end
      end
   end

   // ---------------------------------------------------------------- cosine numerator
   always_comb begin
      xx_in   = side_ff[ST_IN].x * side_ff[ST_IN].x;
      yy_in   = side_ff[ST_IN].y * side_ff[ST_IN].y;
      l1sq_in = side_ff[ST_IN].l1 * side_ff[ST_IN].l1;
      l2sq_in = side_ff[ST_IN].l2 * side_ff[ST_IN].l2;
      lprod   = side_ff[ST_IN].l1 * side_ff[ST_IN].l2;
      den1_in = {lprod, 1'b0};
      num_in  = NUM_W'(xx_ff) + NUM_W'(yy_ff) - NUM_W'(l1sq_ff) - NUM_W'(l2sq_ff);
      num_neg = num_ff[NUM_W-1];
      magw    = num_neg ? -num_ff : num_ff;
      // out of reach: clamping the magnitude to the denominator gives exactly one
      num_far = magw > NUM_W'(den2_ff);
      mag_in  = num_far ? den2_ff : magw[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         xx_ff   <= xx_in;
         yy_ff   <= yy_in;
         l1sq_ff <= l1sq_in;
         l2sq_ff <= l2sq_in;
         den1_ff <= den1_in;
         num_ff  <= num_in;
         den2_ff <= den1_ff;
         mag_ff  <= mag_in;
         den3_ff <= den2_ff;
      end
   end

   // ---------------------------------------------------------------- divider row
   // dividend is mag * 2^30 + den / 2, so the half-denominator bits feed the low end
   genvar gj, gg;
   generate
      for (gj = 0; gj < DIV_CELLS; gj++) begin : g_div
         if (gj == 0) begin : g_first
            assign div_up[gj].rem = {1'b0, mag_ff[DEN_W-1:1]};
            assign div_up[gj].den = den3_ff;
            assign div_up[gj].q   = '0;
            assign div_bit[gj]    = mag_ff[0];
         end else begin : g_rest
            assign div_up[gj]  = div_dn[gj-1];
            assign div_bit[gj] = div_dn[gj-1].den[DEN_W-gj];
         end
         tlik_div_cell u_cell (
            .clock  (clock),
            .en     (adv),
            .bit_in (div_bit[gj]),
            .up     (div_up[gj]),
            .down   (div_dn[gj])
         );
      end
   endgenerate

   assign quo = div_dn[DIV_CELLS-1].q;

   // ---------------------------------------------------------------- sine radicand
   always_comb begin
      csq_in = side_ff[ST_C].c * side_ff[ST_C].c;
      rad_in = (RAD_W'(1) << (2 * ONE_SHIFT)) - RAD_W'(csq_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         csq_ff <= csq_in;
         rad_ff <= rad_in;
      end
   end

   // ---------------------------------------------------------------- square root row
   generate
      for (gj = 0; gj < SQRT_CELLS; gj++) begin : g_sqrt
         if (gj == 0) begin : g_first
            assign sq_up[gj].rem  = '0;
            assign sq_up[gj].root = '0;
            assign sq_up[gj].rad  = rad_ff;
         end else begin : g_rest
            assign sq_up[gj] = sq_dn[gj-1];
         end
         assign sq_pair[gj] = sq_up[gj].rad[RAD_W-1-2*gj -: 2];
         tlik_sqrt_cell u_cell (
            .clock (clock),
            .en    (adv),
            .pair  (sq_pair[gj]),
            .up    (sq_up[gj]),
            .down  (sq_dn[gj])
         );
      end
   endgenerate

   // ---------------------------------------------------------------- offset angle operands
   always_comb begin
      ps_in = side_ff[ST_G1-1].l2 * sq_dn[SQRT_CELLS-1].root;
      pc_in = $signed({1'b0, side_ff[ST_G1-1].l2}) * side_ff[ST_G1-1].c;
      gx_in = (GX_W'(side_ff[ST_G2-1].l1) << ONE_SHIFT) + pc_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ps_ff <= ps_in;
         pc_ff <= pc_in;
         s1_ff <= sq_dn[SQRT_CELLS-1].root;
         gy_ff <= ps_ff;
         gx_ff <= gx_in;
         s2_ff <= s1_ff;
      end
   end

   // ---------------------------------------------------------------- pre-rotation
   always_comb begin
      op_x[GRP_ALPHA] = CV_W'(side_ff[ST_PRE-1].x) <<< PRESCALE;
      op_y[GRP_ALPHA] = CV_W'(side_ff[ST_PRE-1].y) <<< PRESCALE;
      op_x[GRP_BETA]  = CV_W'(side_ff[ST_PRE-1].c);
      op_y[GRP_BETA]  = CV_W'(s2_ff);
      op_x[GRP_GAMMA] = CV_W'(gx_ff);
      op_y[GRP_GAMMA] = CV_W'(gy_ff);
      for (int g = 0; g < ANGLE_GROUPS; g++) begin
         zero_in[g] = (op_x[g] == '0) && (op_y[g] == '0);
         pre_in[g]  = cordic_prerot(op_x[g], op_y[g]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int g = 0; g < ANGLE_GROUPS; g++) begin
            pre_ff[g] <= pre_in[g];
         end
      end
   end

   // ---------------------------------------------------------------- cordic rows
   generate
      for (gg = 0; gg < ANGLE_GROUPS; gg++) begin : g_grp
         for (gj = 0; gj < CORDIC_STEPS; gj++) begin : g_step
            tlik_cordic_cell u_cell (
               .clock (clock),
               .en    (adv),
               .step  (IDX_W'(gj)),
               .up    ((gj == 0) ? pre_ff[gg] : cd_dn[gg][(gj == 0) ? 0 : gj-1]),
               .down  (cd_dn[gg][gj])
            );
         end
      end
   endgenerate

   // ---------------------------------------------------------------- angle combine
   always_comb begin
      for (int g = 0; g < ANGLE_GROUPS; g++) begin
         // both operands zero give a zero angle
         ang[g] = side_ff[ST_FIN-1].zero[g] ? '0 : cd_dn[g][CORDIC_STEPS-1].z;
      end
      sh_in  = RAW_W'(ang[GRP_ALPHA]) - RAW_W'(ang[GRP_GAMMA]);
      el_in  = RAW_W'(DEG180) - RAW_W'(ang[GRP_BETA]);
      sh_rnd = (sh_ff + ROUND_HALF) >>> 8;
      el_rnd = (el_ff + ROUND_HALF) >>> 8;
      sh_cl  = sh_rnd;
      if (sh_rnd < SHOULDER_MIN) begin
         sh_cl = SHOULDER_MIN;
      end
      if (sh_rnd > SHOULDER_MAX) begin
         sh_cl = SHOULDER_MAX;
      end
      el_cl = el_rnd;
      if (el_rnd < ELBOW_MIN) begin
         el_cl = ELBOW_MIN;
      end
      if (el_rnd > ELBOW_MAX) begin
         el_cl = ELBOW_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sh_ff       <= sh_in;
         el_ff       <= el_in;
         rsp_sh_ff   <= sh_cl[SHOULDER_W-1:0];
         rsp_el_ff   <= el_cl[ELBOW_W-1:0];
         rsp_flag_ff <= side_ff[ST_FIN].flag;
      end
   end

   assign rsp_shoulder_angle = rsp_sh_ff;
   assign rsp_elbow_angle    = rsp_el_ff;
   assign rsp_out_of_reach   = rsp_flag_ff;

   // ---------------------------------------------------------------- assertions
   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[0])
      else $error("accepted transaction did not enter the pipeline");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved during an output stall");

   a_elbow_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_elbow_angle <= ELBOW_W'(ELBOW_MAX)))
      else $error("elbow angle beyond half a turn");

   a_shoulder_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (RAW_W'(rsp_shoulder_angle) >= SHOULDER_MIN &&
                     RAW_W'(rsp_shoulder_angle) <= SHOULDER_MAX))
      else $error("shoulder angle outside its clamp range");

endmodule
